### sv/esd_pkg.sv
// Shared constants and types for the escape sequence decoder.
package esd_pkg;

	// Output capacity of one string, counting the end-of-string slot.
	localparam int OUT_CAP = 256;
	localparam int CNT_W   = $clog2(OUT_CAP);
	localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(OUT_CAP - 1);

	// Result queue between the front and back parts.
	localparam int QDEPTH = 4;
	localparam int QA_W   = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		ST_BYTE     = 2'd0,
		ST_END      = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] out_byte;
		status_t    status;
	} res_t;

	// One queue entry holds every result of one input item.
	typedef struct packed {
		res_t r0;
		res_t r1;
		logic two;
	} q_entry_t;

	typedef struct packed {
		logic     push;
		q_entry_t data;
	} q_push_t;

endpackage

### sv/esd_if.sv
// Handshake channels for source items and decoded results.
interface esd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] src_byte;
	logic       end_of_string;

	modport source (output valid, output src_byte, output end_of_string, input ready);
	modport sink (input valid, input src_byte, input end_of_string, output ready);
endinterface

interface esd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last_of_run;

	modport source (output valid, output out_byte, output status, output last_of_run,
		input ready);
	modport sink (input valid, input out_byte, input status, input last_of_run,
		output ready);
endinterface

### sv/esd_front.sv
// Front part: accepts source items, runs the escape decoder, queues results.
module esd_front
	import esd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	esd_in_if.sink        src,
	input  logic          q_full,
	output q_push_t       q_push
);

	typedef enum logic [1:0] {
		M_NORMAL = 2'd0,
		M_ESCAPE = 2'd1,
		M_OCTAL  = 2'd2,
		M_HEX    = 2'd3
	} mode_t;

	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_X    = 8'h78;
	localparam logic [7:0] CH_ZERO = 8'h30;

	mode_t            mode_q, mode_d;
	logic [1:0]       dc_q, dc_d;
	logic [7:0]       esc_q, esc_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_t;
	logic             ovf_q, ovf_d;

	logic       accept;
	logic [7:0] c;
	logic       is_oct;
	logic [4:0] hex;
	logic       do_tok;
	logic       flush_v, tok_v;
	logic [7:0] flush_b;
	res_t       tok;
	logic [7:0] run_byte;
	logic [7:0] oct_nv, hex_nv;

	function automatic logic [4:0] hex_digit(input logic [7:0] ch);
		logic [4:0] r;
		r = 5'd0;
		if (ch inside {[8'h30:8'h39]})
			r = {1'b1, ch[3:0]};
		else if (ch inside {[8'h61:8'h66], [8'h41:8'h46]})
			r = {1'b1, ch[3:0] + 4'd9};
		return r;
	endfunction

	function automatic logic [7:0] simple_escape(input logic [7:0] ch);
		logic [7:0] r;
		case (ch)
			8'h61:   r = 8'h07;
			8'h62:   r = 8'h08;
			8'h66:   r = 8'h0C;
			8'h6E:   r = 8'h0A;
			8'h72:   r = 8'h0D;
			8'h74:   r = 8'h09;
			8'h76:   r = 8'h0B;
			default: r = ch;
		endcase
		return r;
	endfunction

	assign src.ready = !q_full;
	assign accept    = src.valid && src.ready;
	assign c         = src.src_byte;
	assign is_oct    = c inside {[8'h30:8'h37]};
	assign hex       = hex_digit(c);
	assign oct_nv    = {esc_q[4:0], c[2:0]};
	assign hex_nv    = {esc_q[3:0], hex[3:0]};
	assign run_byte  = (mode_q == M_HEX && dc_q == 2'd0) ? CH_X : esc_q;

	always_comb begin
		mode_d  = mode_q;
		dc_d    = dc_q;
		esc_d   = esc_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		flush_v = 1'b0;
		flush_b = run_byte;
		tok_v   = 1'b0;
		tok     = '{out_byte: 8'd0, status: ST_BYTE};
		do_tok  = 1'b0;
		cnt_t   = cnt_q;

		if (src.end_of_string) begin
			flush_v = !ovf_q && (mode_q == M_OCTAL || mode_q == M_HEX);
			tok_v   = 1'b1;
			tok     = '{out_byte: 8'd0, status: ST_END};
			mode_d  = M_NORMAL;
			dc_d    = 2'd0;
			esc_d   = 8'd0;
			cnt_d   = '0;
			ovf_d   = 1'b0;
		end else if (!ovf_q) begin
			case (mode_q)
				M_ESCAPE: begin
					if (is_oct) begin
						mode_d = M_OCTAL;
						esc_d  = c - CH_ZERO;
						dc_d   = 2'd1;
					end else if (c == CH_X) begin
						mode_d = M_HEX;
						esc_d  = 8'd0;
						dc_d   = 2'd0;
					end else begin
						tok_v  = 1'b1;
						tok    = '{out_byte: simple_escape(c), status: ST_BYTE};
						cnt_d  = cnt_q + 1'b1;
						mode_d = M_NORMAL;
						esc_d  = 8'd0;
						dc_d   = 2'd0;
					end
				end
				M_OCTAL: begin
					if (is_oct) begin
						if (dc_q == 2'd2) begin
							tok_v  = 1'b1;
							tok    = '{out_byte: oct_nv, status: ST_BYTE};
							cnt_d  = cnt_q + 1'b1;
							mode_d = M_NORMAL;
							esc_d  = 8'd0;
							dc_d   = 2'd0;
						end else begin
							esc_d = oct_nv;
							dc_d  = dc_q + 2'd1;
						end
					end else begin
						flush_v = 1'b1;
						do_tok  = 1'b1;
					end
				end
				M_HEX: begin
					if (hex[4]) begin
						if (dc_q == 2'd1) begin
							tok_v  = 1'b1;
							tok    = '{out_byte: hex_nv, status: ST_BYTE};
							cnt_d  = cnt_q + 1'b1;
							mode_d = M_NORMAL;
							esc_d  = 8'd0;
							dc_d   = 2'd0;
						end else begin
							esc_d = hex_nv;
							dc_d  = dc_q + 2'd1;
						end
					end else begin
						flush_v = 1'b1;
						do_tok  = 1'b1;
					end
				end
				default: do_tok = 1'b1;
			endcase

			// new token: capacity check counts a byte flushed just before it
			if (do_tok) begin
				cnt_t  = flush_v ? cnt_q + 1'b1 : cnt_q;
				mode_d = M_NORMAL;
				esc_d  = 8'd0;
				dc_d   = 2'd0;
				cnt_d  = cnt_t;
				if (cnt_t >= CAP_LIM) begin
					ovf_d = 1'b1;
					tok_v = 1'b1;
					tok   = '{out_byte: 8'd0, status: ST_OVERFLOW};
				end else if (c == CH_BSL) begin
					mode_d = M_ESCAPE;
				end else begin
					tok_v = 1'b1;
					tok   = '{out_byte: c, status: ST_BYTE};
					cnt_d = cnt_t + 1'b1;
				end
			end
		end
	end

	always_comb begin
		q_push.push     = accept && (flush_v || tok_v);
		q_push.data.r0  = flush_v ? '{out_byte: flush_b, status: ST_BYTE} : tok;
		q_push.data.r1  = tok;
		q_push.data.two = flush_v && tok_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			dc_q   <= 2'd0;
			esc_q  <= 8'd0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			dc_q   <= dc_d;
			esc_q  <= esc_d;
			cnt_q  <= cnt_d;
			ovf_q  <= ovf_d;
		end
	end

endmodule

### sv/esd_queue.sv
// Small queue of per-item result entries between front and back.
module esd_queue
	import esd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  q_push_t  q_push,
	input  logic     pop,
	output logic     full,
	output logic     not_empty,
	output q_entry_t head
);

	q_entry_t        mem_q [QDEPTH];
	logic [QA_W-1:0] wr_q, rd_q;
	logic [QA_W:0]   cnt_q;
	logic            do_pop;

	assign full      = cnt_q == (QA_W+1)'(QDEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (q_push.push)
			mem_q[wr_q] <= q_push.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (q_push.push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			case ({q_push.push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### sv/esd_back.sv
// Back part: output register that plays out one or two results per entry.
module esd_back
	import esd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  q_entry_t  q_head,
	output logic      pop,
	esd_out_if.source dst
);

	logic     busy_q;
	logic     phase_q;
	q_entry_t ent_q;
	logic     last_now;
	logic     done;
	res_t     cur;

	assign last_now        = phase_q || !ent_q.two;
	assign cur             = phase_q ? ent_q.r1 : ent_q.r0;
	assign done            = !busy_q || (dst.ready && last_now);
	assign pop             = done && q_valid;

	assign dst.valid       = busy_q;
	assign dst.out_byte    = cur.out_byte;
	assign dst.status      = cur.status;
	assign dst.last_of_run = last_now;

	always_ff @(posedge clk) begin
		if (pop)
			ent_q <= q_head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (done) begin
			busy_q  <= q_valid;
			phase_q <= 1'b0;
		end else if (dst.ready) begin
			phase_q <= 1'b1;
		end
	end

endmodule

### sv/escape_sequence_decoder.sv
// Top level of the streaming escape sequence decoder.
//
//  channel  dir  payload                              transfer when
//  src      in   src_byte[7:0], end_of_string         src.valid && src.ready
//  dst      out  out_byte[7:0], status[1:0],          dst.valid && dst.ready
//                last_of_run
//
// One source item is taken per cycle unless the queue is full. The front
// decoder updates its state in the cycle of the transfer and writes the results
// of that item as one entry into a four-entry queue. The back part plays out
// one result per cycle unless stalled, so an item with two results (digit run
// flush plus a new token, or flush plus end of string) holds the back for both;
// the queue absorbs this and src.ready drops only while the queue is full. The
// output register holds its result while dst.ready is low. Reset clears the
// decoder state, the queue and the output register; no clearing pass is needed.
module escape_sequence_decoder
	import esd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	esd_in_if.sink    src,
	esd_out_if.source dst
);

	q_push_t  q_push;
	q_entry_t q_head;
	logic     q_full;
	logic     q_valid;
	logic     q_pop;

	// decoder state machine and result classification
	esd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.q_full (q_full),
		.q_push (q_push)
	);

	// decouples the decoder from output stalls
	esd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_push    (q_push),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	// result sequencing and output register
	esd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.pop     (q_pop),
		.dst     (dst)
	);

endmodule

### tb/sv/tb_escape_sequence_decoder.sv
// Self-checking testbench for the escape sequence decoder: directed and random strings.
module tb_escape_sequence_decoder;
	import esd_pkg::*;

	// Run ends with a failure if this many cycles pass; the slowest legal run is
	// far below it even with every item giving two results under heavy stalls.
	localparam int CYCLE_LIMIT  = 400000;
	// Directed tests send about 1375 items; random strings make up the rest.
	localparam int RANDOM_ITEMS = 475;
	localparam logic [7:0] BSL  = 8'h5C;

	// Decoder modes, mirrored from the block's behavior.
	typedef enum logic [1:0] {
		M_NORMAL = 2'd0,
		M_ESCAPE = 2'd1,
		M_OCTAL  = 2'd2,
		M_HEX    = 2'd3
	} dec_mode_t;

	// One decoded result as the output channel should show it.
	typedef struct packed {
		logic [7:0] out_byte;
		status_t    status;
		logic       last;
	} dec_res_t;

	logic clk;
	logic arst_n;

	esd_in_if  src_if ();
	esd_out_if dst_if ();

	escape_sequence_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_if),
		.dst    (dst_if)
	);

	// Decoded results still owed by the block, oldest first.
	dec_res_t decoded_q[$];
	dec_res_t item_results[$];

	// Shadow copy of the decoder state.
	dec_mode_t  dmode       = M_NORMAL;
	logic [1:0] digit_cnt   = '0;
	logic [7:0] run_value   = '0;
	int         out_count   = 0;
	logic       over_cap    = 1'b0;

	int          mismatches = 0;
	int          cycles     = 0;
	int          burst_left = 0;
	logic [31:0] rx_cycle   = '0;

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Decoder model
	// ------------------------------------------------------------------

	function automatic void add_result(logic [7:0] b, status_t st);
		dec_res_t r;
		r.out_byte = b;
		r.status   = st;
		r.last     = 1'b0;
		item_results.push_back(r);
	endfunction

	// A decoded byte always closes any escape in progress.
	function automatic void add_byte(logic [7:0] b);
		add_result(b, ST_BYTE);
		if (out_count < OUT_CAP)
			out_count++;
		dmode     = M_NORMAL;
		digit_cnt = '0;
		run_value = '0;
	endfunction

	// Pending digit run: octal gives its value, hex with no digits gives 'x'.
	function automatic void flush_digits();
		if (dmode == M_OCTAL)
			add_byte(run_value);
		else if (dmode == M_HEX)
			add_byte(digit_cnt != 0 ? run_value : "x");
	endfunction

	// Capacity is checked when a plain character or a backslash starts a token.
	function automatic void start_token(logic [7:0] c);
		if (out_count + 1 >= OUT_CAP) begin
			over_cap  = 1'b1;
			dmode     = M_NORMAL;
			digit_cnt = '0;
			run_value = '0;
			add_result(8'h00, ST_OVERFLOW);
			return;
		end
		if (c == BSL)
			dmode = M_ESCAPE;
		else
			add_byte(c);
	endfunction

	// Works out every result of one accepted input item and queues them.
	function automatic void decode_item(logic [7:0] c, logic eos);
		int hexd;
		logic [7:0] esc;
		item_results.delete();
		hexd = -1;
		if (c >= "0" && c <= "9")
			hexd = c - "0";
		else if (c >= "a" && c <= "f")
			hexd = c - "a" + 10;
		else if (c >= "A" && c <= "F")
			hexd = c - "A" + 10;

		if (eos) begin
			if (!over_cap)
				flush_digits();
			add_result(8'h00, ST_END);
			dmode     = M_NORMAL;
			digit_cnt = '0;
			run_value = '0;
			out_count = 0;
			over_cap  = 1'b0;
		end else if (!over_cap) begin
			case (dmode)
				M_ESCAPE: begin
					if (c >= "0" && c <= "7") begin
						dmode     = M_OCTAL;
						run_value = c - "0";
						digit_cnt = 2'd1;
					end else if (c == "x") begin
						dmode     = M_HEX;
						run_value = '0;
						digit_cnt = '0;
					end else begin
						case (c)
							"a":     esc = 8'h07;
							"b":     esc = 8'h08;
							"f":     esc = 8'h0C;
							"n":     esc = 8'h0A;
							"r":     esc = 8'h0D;
							"t":     esc = 8'h09;
							"v":     esc = 8'h0B;
							default: esc = c;
						endcase
						add_byte(esc);
					end
				end
				M_OCTAL: begin
					if (c >= "0" && c <= "7") begin
						// keep the low 8 bits: three digits may exceed 377
						run_value = 8'({run_value, 3'b000} + (c - "0"));
						digit_cnt++;
						if (digit_cnt >= 2'd3)
							add_byte(run_value);
					end else begin
						flush_digits();
						start_token(c);
					end
				end
				M_HEX: begin
					if (hexd >= 0) begin
						run_value = 8'({run_value, 4'b0000} + hexd);
						digit_cnt++;
						if (digit_cnt >= 2'd2)
							add_byte(run_value);
					end else begin
						flush_digits();
						start_token(c);
					end
				end
				default: start_token(c);
			endcase
		end

		if (item_results.size() > 0)
			item_results[item_results.size()-1].last = 1'b1;
		foreach (item_results[i])
			decoded_q.push_back(item_results[i]);
	endfunction

	// ------------------------------------------------------------------
	// Source side
	// ------------------------------------------------------------------

	// Sends one item. The sender runs in bursts; between bursts valid drops for
	// a random gap, and about a third of the bursts follow with no gap at all.
	task automatic send_item(input logic [7:0] b, input logic eos);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				src_if.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		src_if.valid         = 1'b1;
		src_if.src_byte      = b;
		src_if.end_of_string = eos;
		do
			@(posedge clk);
		while (src_if.ready !== 1'b1);
		// transfer taken at this edge; valid stays high until the next item
		decode_item(b, eos);
	endtask

	// Characters of s, then the terminator with a don't-care byte.
	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Plain lowercase letters to bring the output count near capacity.
	task automatic send_filler(input int n);
		repeat (n) send_item(8'($urandom_range(97, 122)), 1'b0);
	endtask

	// ------------------------------------------------------------------
	// Sink side
	// ------------------------------------------------------------------

	// Stall pattern cycles through four phases: always ready,
	// light random stalls, periodic long stalls, heavy random stalls.
	always @(negedge clk) begin
		rx_cycle = rx_cycle + 1;
		case (rx_cycle[9:8])
			2'd0:    dst_if.ready = 1'b1;
			2'd1:    dst_if.ready = ($urandom_range(0, 3) != 0);
			2'd2:    dst_if.ready = (rx_cycle[2:0] < 3'd3);
			default: dst_if.ready = ($urandom_range(0, 3) == 0);
		endcase
	end

	// Every transfer on the output is checked against the oldest expectation.
	always @(posedge clk) begin
		dec_res_t want;
		if (arst_n && dst_if.valid === 1'b1 && dst_if.ready === 1'b1) begin
			if (decoded_q.size() == 0) begin
				$error("result with nothing expected: out_byte %0h status %0d last_of_run %0b",
					dst_if.out_byte, dst_if.status, dst_if.last_of_run);
				mismatches++;
			end else begin
				want = decoded_q.pop_front();
				if (dst_if.out_byte !== want.out_byte) begin
					$error("out_byte expected %0h actual %0h", want.out_byte, dst_if.out_byte);
					mismatches++;
				end
				if (dst_if.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, dst_if.status);
					mismatches++;
				end
				if (dst_if.last_of_run !== want.last) begin
					$error("last_of_run expected %0b actual %0b", want.last,
						dst_if.last_of_run);
					mismatches++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// All seven control codes, the three self-standing escapes, an unknown one.
	task automatic test_simple_escapes();
		send_text("\\a\\b\\f\\n\\r\\t\\v\\\\\\\"\\/\\q");
	endtask

	// Octal runs of one, two and three digits, ended by a backslash, a letter,
	// the run length and the terminator; 777 and 400 wrap to 8 bits.
	task automatic test_octal_runs();
		send_text("\\7\\12A\\101\\777\\4001");
		send_text("\\5");
	endtask

	// Hex with no digits, one digit and two digits, mixed case, ended by a
	// non-digit, a backslash and the terminator.
	task automatic test_hex_runs();
		send_text("\\xg\\x4z\\xAf\\xB\\x");
		send_text("\\x");
	endtask

	// Byte extremes, an escaped 0xFF, an empty string, a lone trailing backslash.
	task automatic test_edge_bytes();
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(BSL, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b1);
		send_text("ab\\");
	endtask

	// Strings that run into the capacity limit from each kind of token.
	task automatic test_overflow();
		send_filler(255);
		send_text("z\\5ab\\");     // plain token overflows, rest ignored
		send_filler(254);
		send_text("\\12A");        // octal flush fills the last slot, then overflow
		send_filler(255);
		send_text("\\n");          // backslash token overflows
		send_filler(253);
		send_text("\\x4");         // flush on terminator just fits
		send_filler(254);
		send_text("\\xq");         // literal x, then overflow
		send_text("ok");           // decoder recovers after the terminator
	endtask

	// One well-formed token or a bit of noise appended to a string.
	function automatic void add_token(ref logic [7:0] txt[$]);
		string simple;
		string hexchars;
		int n;
		simple   = "abfnrtv\\\"/";
		hexchars = "0123456789abcdefABCDEF";
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				txt.push_back(8'($urandom_range(1, 255)));
				if (txt[txt.size()-1] == BSL)
					txt.push_back(BSL);
			end
			4: begin
				txt.push_back(BSL);
				txt.push_back(simple[$urandom_range(0, simple.len() - 1)]);
			end
			5: begin
				txt.push_back(BSL);
				txt.push_back(8'($urandom_range(1, 255)));
			end
			6: begin
				txt.push_back(BSL);
				n = $urandom_range(1, 3);
				repeat (n) txt.push_back(8'($urandom_range(48, 55)));
			end
			7: begin
				txt.push_back(BSL);
				txt.push_back("x");
				n = $urandom_range(0, 2);
				repeat (n) txt.push_back(hexchars[$urandom_range(0, hexchars.len() - 1)]);
			end
			8:       txt.push_back(8'($urandom_range(1, 255)));
			default: txt.push_back(BSL);
		endcase
	endfunction

	// Random strings: mostly short, one in ten of 240 to 280 items, near or past capacity.
	task automatic test_random_strings();
		logic [7:0] txt[$];
		int target;
		int sent;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			txt.delete();
			target = ($urandom_range(0, 9) == 0) ? $urandom_range(240, 280)
				: $urandom_range(0, 24);
			while (txt.size() < target)
				add_token(txt);
			foreach (txt[i]) begin
				sent++;
				send_item(txt[i], 1'b0);
			end
			sent++;
			send_item(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		src_if.valid         = 1'b0;
		src_if.src_byte      = 8'h00;
		src_if.end_of_string = 1'b0;
		dst_if.ready         = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_simple_escapes();
		test_octal_runs();
		test_hex_runs();
		test_edge_bytes();
		test_overflow();
		test_random_strings();

		@(negedge clk);
		src_if.valid = 1'b0;

		// Drain, then keep the clock running to catch stray results.
		wait (decoded_q.size() == 0);
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
